// ===== sv/clc_pkg.sv =====
// Types, codes and the transition decoder of the coherence line controller.
// No dependencies; used by every other file of the block.
`default_nettype none
package clc_pkg;

  localparam logic [2:0] ST_I  = 3'd0;
  localparam logic [2:0] ST_M  = 3'd1;
  localparam logic [2:0] ST_S  = 3'd2;
  localparam logic [2:0] ST_E  = 3'd3;
  localparam logic [2:0] ST_IM = 3'd4;
  localparam logic [2:0] ST_IS = 3'd5;
  localparam logic [2:0] ST_IE = 3'd6;

  localparam logic [1:0] BUS_RD     = 2'd0;
  localparam logic [1:0] BUS_WR     = 2'd1;
  localparam logic [1:0] BUS_DATA   = 2'd2;
  localparam logic [1:0] BUS_SHARED = 2'd3;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_INV  = 2'd1;
  localparam logic [1:0] ACT_RECV = 2'd2;

  localparam logic [1:0] MODE_MI   = 2'd0;
  localparam logic [1:0] MODE_MSI  = 2'd1;
  localparam logic [1:0] MODE_MESI = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic OP_PROC  = 1'b0;
  localparam logic OP_SNOOP = 1'b1;

  localparam int AddrWidth = 64;
  localparam int ProcWidth = 4;

  typedef struct packed {
    logic [2:0]           next_state;
    logic                 permission;
    logic [1:0]           line_action;
    logic                 bad_state;
    logic [1:0]           nmsg;
    logic [1:0]           kind0;
    logic [1:0]           kind1;
    logic [AddrWidth-1:0] addr;
    logic [ProcWidth-1:0] proc;
  } clc_entry_t;

  function automatic clc_entry_t clc_decide(logic [1:0] mode_raw, logic op, logic wr,
                                            logic [1:0] kind, logic [2:0] st);
    clc_entry_t e;
    logic [1:0] m;
    logic       sup;
    logic       reply;
    m     = (mode_raw == MODE_RSVD) ? MODE_MESI : mode_raw;
    reply = (kind == BUS_DATA) || (kind == BUS_SHARED);
    e     = '0;
    e.next_state = st;
    unique case (st)
      ST_I, ST_M, ST_IM: sup = 1'b1;
      ST_S:              sup = (m != MODE_MI);
      ST_IS:             sup = (m == MODE_MSI);
      ST_E, ST_IE:       sup = (m == MODE_MESI);
      default:           sup = 1'b0;
    endcase
    if (!sup) begin
      e.bad_state  = 1'b1;
      e.next_state = ST_I;
    end else if (op == OP_PROC) begin
      unique case (st)
        ST_I: begin
          e.nmsg = 2'd1;
          if (m == MODE_MI || wr) begin
            e.kind0      = BUS_WR;
            e.next_state = ST_IM;
          end else begin
            e.kind0      = BUS_RD;
            e.next_state = (m == MODE_MSI) ? ST_IS : ST_IE;
          end
        end
        ST_M: e.permission = 1'b1;
        ST_S: begin
          if (wr) begin
            e.nmsg       = 2'd1;
            e.kind0      = BUS_WR;
            e.next_state = ST_IM;
          end else begin
            e.permission = 1'b1;
          end
        end
        ST_E: begin
          e.permission = 1'b1;
          if (wr) e.next_state = ST_M;
        end
        default: ;
      endcase
    end else begin
      unique case (st)
        ST_M: begin
          if (m == MODE_MI || kind == BUS_WR) begin
            e.nmsg        = 2'd1;
            e.kind0       = BUS_DATA;
            e.line_action = ACT_INV;
            e.next_state  = ST_I;
          end else if (kind == BUS_RD) begin
            e.kind0      = BUS_DATA;
            e.kind1      = BUS_SHARED;
            e.nmsg       = (m == MODE_MSI) ? 2'd1 : 2'd2;
            e.next_state = ST_S;
          end
        end
        ST_IM: begin
          if (reply) begin
            e.line_action = ACT_RECV;
            e.next_state  = ST_M;
          end
        end
        ST_IS: begin
          if (reply) begin
            e.line_action = ACT_RECV;
            e.next_state  = ST_S;
          end
        end
        ST_IE: begin
          if (kind == BUS_SHARED) begin
            e.line_action = ACT_RECV;
            e.next_state  = ST_S;
          end else if (kind == BUS_DATA) begin
            e.line_action = ACT_RECV;
            e.next_state  = ST_E;
          end
        end
        ST_S, ST_E: begin
          if (kind == BUS_WR) begin
            e.line_action = ACT_INV;
            e.next_state  = ST_I;
          end else if (kind == BUS_RD) begin
            e.kind0      = BUS_SHARED;
            e.nmsg       = (m == MODE_MSI) ? 2'd0 : 2'd1;
            e.next_state = ST_S;
          end
        end
        default: ;
      endcase
    end
    return e;
  endfunction

endpackage
`default_nettype wire

// ===== sv/clc_if.sv =====
// Channel interfaces of the coherence line controller: request, result, mode write.
// Depends on clc_pkg for field widths.
`default_nettype none
interface clc_req_if import clc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic                 is_write;
  logic [1:0]           bus_kind;
  logic [2:0]           line_state;
  logic [AddrWidth-1:0] line_addr;
  logic [ProcWidth-1:0] requester;
  modport source (output valid, op, is_write, bus_kind, line_state, line_addr, requester,
                  input ready);
  modport sink (input valid, op, is_write, bus_kind, line_state, line_addr, requester,
                output ready);
endinterface

interface clc_rsp_if import clc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           next_state;
  logic                 permission;
  logic [1:0]           line_action;
  logic                 msg_valid;
  logic [1:0]           msg_kind;
  logic [AddrWidth-1:0] msg_addr;
  logic [ProcWidth-1:0] msg_proc;
  logic                 bad_state;
  logic                 last;
  modport source (output valid, next_state, permission, line_action, msg_valid, msg_kind,
                  msg_addr, msg_proc, bad_state, last, input ready);
  modport sink (input valid, next_state, permission, line_action, msg_valid, msg_kind,
                msg_addr, msg_proc, bad_state, last, output ready);
endinterface

interface clc_cfg_if ();
  logic       valid;
  logic       ready;
  logic [1:0] protocol_mode;
  modport source (output valid, protocol_mode, input ready);
  modport sink (input valid, protocol_mode, output ready);
endinterface
`default_nettype wire

// ===== sv/clc_front.sv =====
// Front end: holds the mode register, accepts transactions and decodes the transition.
// Depends on clc_pkg and clc_if.
`default_nettype none
module clc_front import clc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  clc_req_if.sink     req,
  clc_cfg_if.sink     cfg,
  input  wire logic   q_ready_i,
  output logic        q_push_o,
  output clc_entry_t  q_entry_o
);

  logic [1:0] mode_q;
  logic [1:0] mode_d;
  clc_entry_t dec;

  assign cfg.ready = 1'b1;
  assign mode_d    = (cfg.valid) ? cfg.protocol_mode : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MESI;
    end else begin
      mode_q <= mode_d;
    end
  end

  always_comb begin
    dec      = clc_decide(mode_q, req.op, req.is_write, req.bus_kind, req.line_state);
    dec.addr = req.line_addr;
    dec.proc = req.requester;
  end

  assign req.ready = q_ready_i;
  assign q_push_o  = req.valid && q_ready_i;
  assign q_entry_o = dec;

endmodule
`default_nettype wire

// ===== sv/clc_queue.sv =====
// Short queue of decoded transitions between front and back end.
// Depends on clc_pkg.
`default_nettype none
module clc_queue import clc_pkg::*; #(
  parameter int Depth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire clc_entry_t  entry_i,
  output logic             ready_o,
  input  wire logic        pop_i,
  output logic             valid_o,
  output clc_entry_t       entry_o
);

  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  clc_entry_t      mem_q [Depth];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign ready_o = (cnt_q != CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    if (pop_i)  rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

endmodule
`default_nettype wire

// ===== sv/clc_back.sv =====
// Back end: holds one decoded transition and sends its one or two result transactions.
// Depends on clc_pkg and clc_if.
`default_nettype none
module clc_back import clc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wire clc_entry_t  q_entry_i,
  output logic             q_pop_o,
  clc_rsp_if.source        rsp
);

  clc_entry_t cur_q;
  logic       busy_q;
  logic       idx_q;
  logic       has_msg;
  logic       is_last;
  logic       fire;
  logic       done;

  assign has_msg = idx_q ? (cur_q.nmsg == 2'd2) : (cur_q.nmsg != 2'd0);
  assign is_last = idx_q || (cur_q.nmsg != 2'd2);
  assign fire    = busy_q && rsp.ready;
  assign done    = fire && is_last;
  assign q_pop_o = q_valid_i && (!busy_q || done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 1'b0;
    end else if (q_pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= 1'b0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (fire) begin
      idx_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_entry_i;
  end

  assign rsp.valid       = busy_q;
  assign rsp.next_state  = cur_q.next_state;
  assign rsp.permission  = cur_q.permission;
  assign rsp.line_action = cur_q.line_action;
  assign rsp.bad_state   = cur_q.bad_state;
  assign rsp.msg_valid   = has_msg;
  assign rsp.msg_kind    = has_msg ? (idx_q ? cur_q.kind1 : cur_q.kind0) : BUS_RD;
  assign rsp.msg_addr    = has_msg ? cur_q.addr : '0;
  assign rsp.msg_proc    = has_msg ? cur_q.proc : '0;
  assign rsp.last        = is_last;

endmodule
`default_nettype wire

// ===== sv/coherence_line_controller.sv =====
// Coherence line controller top level: front end, transition queue, back end.
// Depends on clc_pkg, clc_if, clc_front, clc_queue and clc_back.
//
// Channels: req takes one processor access or snooped bus message with the
// line's present state; rsp gives one result transaction per bus message to
// send (at least one), the final one flagged by last; cfg writes the protocol
// mode (MI, MSI, MESI) and is always ready.
// Path: an accepted request is written into the queue, then moved into the
// back end's register cur_q once that is free; the results are driven from it.
// Throughput: one request per cycle while rsp.ready is high and each gives
// one result; a two-message request holds the result port for both. The queue of
// QueueDepth decoded transitions absorbs that and short receiver stalls.
// Reset: mode is MESI, queue and output stage are empty.
// When the receiver stalls, the pending result holds and the queue fills;
// req.ready drops once the queue is full.
`default_nettype none
module coherence_line_controller import clc_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  clc_req_if.sink   req,
  clc_rsp_if.source rsp,
  clc_cfg_if.sink   cfg
);

  logic       q_push;
  logic       q_ready;
  logic       q_pop;
  logic       q_valid;
  clc_entry_t q_in;
  clc_entry_t q_out;

  clc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req),
    .cfg       (cfg),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_entry_o (q_in)
  );

  clc_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  clc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_out),
    .q_pop_o   (q_pop),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

// ===== sv/clc_checker.sv =====
// Port-level checks of the coherence line controller and their bind.
// Depends on clc_pkg and the top level coherence_line_controller.
`default_nettype none
module clc_checker import clc_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [2:0]           next_state,
  input wire logic                 permission,
  input wire logic [1:0]           line_action,
  input wire logic                 msg_valid,
  input wire logic [1:0]           msg_kind,
  input wire logic [AddrWidth-1:0] msg_addr,
  input wire logic [ProcWidth-1:0] msg_proc,
  input wire logic                 bad_state,
  input wire logic                 last
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(next_state) && $stable(last))
    else $error("result changed while stalled");

  a_no_msg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !msg_valid |-> msg_kind == BUS_RD && msg_addr == '0 && msg_proc == '0
                                && last)
    else $error("result without message carries message fields");

  a_bad_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && bad_state |-> next_state == ST_I && !permission
                               && line_action == ACT_NONE && !msg_valid)
    else $error("unsupported state result not forced invalid");

  a_second_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !last |=> out_valid && last && msg_valid
                                        && $stable(next_state))
    else $error("second message of a transaction missing");

endmodule

bind coherence_line_controller clc_checker u_clc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .next_state  (rsp.next_state),
  .permission  (rsp.permission),
  .line_action (rsp.line_action),
  .msg_valid   (rsp.msg_valid),
  .msg_kind    (rsp.msg_kind),
  .msg_addr    (rsp.msg_addr),
  .msg_proc    (rsp.msg_proc),
  .bad_state   (rsp.bad_state),
  .last        (rsp.last)
);
`default_nettype wire

// ===== tb/sv/tb_coherence_line_controller.sv =====
`timescale 1ns / 100ps
// Testbench for coherence_line_controller: directed line requests after reset and
// random ones in every protocol mode, each result checked against a local transition predictor.
// Depends on clc_pkg, clc_if and the coherence_line_controller RTL.
module tb_coherence_line_controller;
  import clc_pkg::*;

  typedef struct packed {
    logic                 op;
    logic                 is_write;
    logic [1:0]           bus_kind;
    logic [2:0]           line_state;
    logic [AddrWidth-1:0] line_addr;
    logic [ProcWidth-1:0] requester;
  } line_req_t;

  typedef struct packed {
    logic [2:0]           next_state;
    logic                 permission;
    logic [1:0]           line_action;
    logic                 msg_valid;
    logic [1:0]           msg_kind;
    logic [AddrWidth-1:0] msg_addr;
    logic [ProcWidth-1:0] msg_proc;
    logic                 bad_state;
    logic                 last;
  } line_result_t;

  localparam logic [2:0]           ST_UNUSED = 3'd7;
  localparam logic [AddrWidth-1:0] ADDR_MAX  = '1;
  localparam logic [ProcWidth-1:0] PROC_MAX  = '1;

  logic clk_i = 1'b0;
  logic rst_ni;

  clc_req_if req_if ();
  clc_rsp_if rsp_if ();
  clc_cfg_if cfg_if ();

  coherence_line_controller i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_if),
    .rsp    (rsp_if),
    .cfg    (cfg_if)
  );

  line_result_t results_due[$];
  logic [1:0]   active_mode = MODE_MESI;
  logic         idling = 1'b1;
  int unsigned  result_hold = 0;
  int unsigned  mismatch_count = 0;

  always #5 clk_i = ~clk_i;

  function automatic void predict_transition(logic [1:0] mode, line_req_t r);
    logic [1:0]   eff;
    logic         supported;
    logic         reply;
    logic [2:0]   nxt;
    logic         perm;
    logic [1:0]   act;
    logic [1:0]   msgs[$];
    line_result_t res;
    int           n;
    int           k;
    eff   = (mode == MODE_RSVD) ? MODE_MESI : mode;
    reply = (r.bus_kind == BUS_DATA) || (r.bus_kind == BUS_SHARED);
    nxt   = r.line_state;
    perm  = 1'b0;
    act   = ACT_NONE;
    if (r.line_state == ST_I || r.line_state == ST_M || r.line_state == ST_IM) begin
      supported = 1'b1;
    end else if (eff == MODE_MI) begin
      supported = 1'b0;
    end else if (eff == MODE_MSI) begin
      supported = (r.line_state == ST_S) || (r.line_state == ST_IS);
    end else begin
      supported = (r.line_state == ST_S) || (r.line_state == ST_E) || (r.line_state == ST_IE);
    end

    if (!supported) begin
      nxt = ST_I;
    end else if (r.op == OP_PROC) begin
      case (r.line_state)
        ST_I: begin
          if (eff == MODE_MI || r.is_write) begin
            msgs.push_back(BUS_WR);
            nxt = ST_IM;
          end else begin
            msgs.push_back(BUS_RD);
            nxt = (eff == MODE_MSI) ? ST_IS : ST_IE;
          end
        end
        ST_M: perm = 1'b1;
        ST_S: begin
          if (r.is_write) begin
            msgs.push_back(BUS_WR);
            nxt = ST_IM;
          end else begin
            perm = 1'b1;
          end
        end
        ST_E: begin
          perm = 1'b1;
          if (r.is_write) nxt = ST_M;
        end
        default: ;
      endcase
    end else begin
      case (r.line_state)
        ST_M: begin
          if (eff == MODE_MI || r.bus_kind == BUS_WR) begin
            msgs.push_back(BUS_DATA);
            act = ACT_INV;
            nxt = ST_I;
          end else if (r.bus_kind == BUS_RD) begin
            msgs.push_back(BUS_DATA);
            if (eff != MODE_MSI) msgs.push_back(BUS_SHARED);
            nxt = ST_S;
          end
        end
        ST_IM: begin
          if (reply) begin
            act = ACT_RECV;
            nxt = ST_M;
          end
        end
        ST_IS: begin
          if (reply) begin
            act = ACT_RECV;
            nxt = ST_S;
          end
        end
        ST_IE: begin
          if (r.bus_kind == BUS_SHARED) begin
            act = ACT_RECV;
            nxt = ST_S;
          end else if (r.bus_kind == BUS_DATA) begin
            act = ACT_RECV;
            nxt = ST_E;
          end
        end
        ST_S, ST_E: begin
          if (r.bus_kind == BUS_WR) begin
            act = ACT_INV;
            nxt = ST_I;
          end else if (r.bus_kind == BUS_RD) begin
            if (eff != MODE_MSI) msgs.push_back(BUS_SHARED);
            nxt = ST_S;
          end
        end
        default: ;
      endcase
    end

    n = (msgs.size() > 0) ? msgs.size() : 1;
    for (k = 0; k < n; k++) begin
      res             = '0;
      res.next_state  = nxt;
      res.permission  = perm;
      res.line_action = act;
      res.bad_state   = !supported;
      if (k < msgs.size()) begin
        res.msg_valid = 1'b1;
        res.msg_kind  = msgs[k];
        res.msg_addr  = r.line_addr;
        res.msg_proc  = r.requester;
      end
      res.last = (k == n - 1);
      results_due.push_back(res);
    end
  endfunction

  function automatic string describe_result(line_result_t r);
    return $sformatf({"next=%0d perm=%0b act=%0d msg=%0b kind=%0d addr=%h proc=%0d ",
                      "bad=%0b last=%0b"}, r.next_state, r.permission, r.line_action,
                     r.msg_valid, r.msg_kind, r.msg_addr, r.msg_proc, r.bad_state, r.last);
  endfunction

  always @(negedge clk_i) begin
    if (result_hold > 0) begin
      rsp_if.ready <= 1'b0;
      result_hold = result_hold - 1;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    line_result_t got;
    line_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.next_state  = rsp_if.next_state;
      got.permission  = rsp_if.permission;
      got.line_action = rsp_if.line_action;
      got.msg_valid   = rsp_if.msg_valid;
      got.msg_kind    = rsp_if.msg_kind;
      got.msg_addr    = rsp_if.msg_addr;
      got.msg_proc    = rsp_if.msg_proc;
      got.bad_state   = rsp_if.bad_state;
      got.last        = rsp_if.last;
      if (results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: got %s", describe_result(got));
      end else begin
        want = results_due.pop_front();
        if (got.next_state !== want.next_state || got.permission !== want.permission ||
            got.line_action !== want.line_action || got.msg_valid !== want.msg_valid ||
            got.msg_kind !== want.msg_kind || got.msg_addr !== want.msg_addr ||
            got.msg_proc !== want.msg_proc || got.bad_state !== want.bad_state ||
            got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", describe_result(want));
            $display("  actual   %s", describe_result(got));
          end
        end
      end
      result_hold = idling ? $urandom_range(0, 4) : 0;
    end
  end

  task automatic send_request(logic op, logic wr, logic [1:0] kind, logic [2:0] st,
                              logic [AddrWidth-1:0] addr, logic [ProcWidth-1:0] proc);
    int unsigned gap;
    line_req_t   r;
    gap = idling ? $urandom_range(0, 4) : 0;
    r   = '{op: op, is_write: wr, bus_kind: kind, line_state: st, line_addr: addr,
            requester: proc};
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.op         <= r.op;
    req_if.is_write   <= r.is_write;
    req_if.bus_kind   <= r.bus_kind;
    req_if.line_state <= r.line_state;
    req_if.line_addr  <= r.line_addr;
    req_if.requester  <= r.requester;
    do @(posedge clk_i); while (!req_if.ready);
    predict_transition(active_mode, r);
  endtask

  // drop the request, drain every owed result, then cover the pipeline latency
  task automatic wait_idle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_protocol_mode(logic [1:0] mode);
    wait_idle();
    @(negedge clk_i);
    cfg_if.valid         <= 1'b1;
    cfg_if.protocol_mode <= mode;
    do @(posedge clk_i); while (!cfg_if.ready);
    active_mode = mode;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_random_traffic(int count);
    logic [AddrWidth-1:0] addr;
    int                   i;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) idling = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 15))
        0: addr = '0;
        1: addr = ADDR_MAX;
        default: addr = {$urandom, $urandom};
      endcase
      send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), addr,
                   ProcWidth'($urandom_range(0, 15)));
    end
  endtask

  task automatic test_mesi_after_reset();
    idling = 1'b1;
    send_request(OP_PROC, 1'b0, BUS_RD, ST_I, '0, '0);
    send_request(OP_PROC, 1'b1, BUS_RD, ST_I, ADDR_MAX, PROC_MAX);
    send_request(OP_PROC, 1'b0, BUS_WR, ST_M, 64'h0123_4567_89ab_cdef, 4'd3);
    send_request(OP_PROC, 1'b1, BUS_RD, ST_S, 64'hfedc_ba98_7654_3210, 4'd9);
    send_request(OP_PROC, 1'b0, BUS_RD, ST_S, ADDR_MAX, '0);
    send_request(OP_PROC, 1'b1, BUS_RD, ST_E, '0, PROC_MAX);
    send_request(OP_PROC, 1'b0, BUS_SHARED, ST_IE, 64'h5555_5555_5555_5555, 4'd5);
    send_request(OP_PROC, 1'b0, BUS_RD, ST_IS, ADDR_MAX, PROC_MAX);
    send_request(OP_SNOOP, 1'b0, BUS_RD, ST_UNUSED, ADDR_MAX, PROC_MAX);
    send_request(OP_SNOOP, 1'b0, BUS_RD, ST_M, ADDR_MAX, PROC_MAX);
    send_request(OP_SNOOP, 1'b0, BUS_WR, ST_M, 64'haaaa_aaaa_aaaa_aaaa, 4'd10);
    send_request(OP_SNOOP, 1'b0, BUS_DATA, ST_M, '0, '0);
    send_request(OP_SNOOP, 1'b1, BUS_SHARED, ST_M, ADDR_MAX, PROC_MAX);
    send_request(OP_SNOOP, 1'b0, BUS_SHARED, ST_IE, 64'h1, 4'd1);
    send_request(OP_SNOOP, 1'b0, BUS_DATA, ST_IE, 64'h8000_0000_0000_0000, 4'd8);
    send_request(OP_SNOOP, 1'b0, BUS_RD, ST_IE, '0, '0);
    send_request(OP_SNOOP, 1'b0, BUS_WR, ST_IE, ADDR_MAX, PROC_MAX);
    send_request(OP_SNOOP, 1'b1, BUS_RD, ST_S, 64'h0f0f_0f0f_f0f0_f0f0, 4'd12);
    send_request(OP_SNOOP, 1'b0, BUS_WR, ST_E, ADDR_MAX, 4'd6);
    send_request(OP_SNOOP, 1'b0, BUS_DATA, ST_S, '0, '0);
    send_request(OP_SNOOP, 1'b0, BUS_SHARED, ST_E, ADDR_MAX, PROC_MAX);
    send_request(OP_SNOOP, 1'b0, BUS_DATA, ST_IM, 64'h00ff_00ff_00ff_00ff, 4'd2);
    send_request(OP_SNOOP, 1'b0, BUS_RD, ST_I, ADDR_MAX, PROC_MAX);
    send_request(OP_PROC, 1'b1, BUS_WR, ST_UNUSED, '0, '0);
  endtask

  task automatic test_mi_mode();
    write_protocol_mode(MODE_MI);
    run_random_traffic(160);
  endtask

  task automatic test_msi_mode();
    write_protocol_mode(MODE_MSI);
    run_random_traffic(160);
  endtask

  task automatic test_mesi_mode();
    write_protocol_mode(MODE_MESI);
    run_random_traffic(160);
  endtask

  task automatic test_reserved_mode();
    write_protocol_mode(MODE_RSVD);
    run_random_traffic(140);
  endtask

  task automatic test_mode_changes();
    write_protocol_mode(MODE_MI);
    run_random_traffic(40);
    write_protocol_mode(MODE_RSVD);
    run_random_traffic(40);
    write_protocol_mode(MODE_MSI);
    run_random_traffic(40);
  endtask

  initial begin
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.op            = OP_PROC;
    req_if.is_write      = 1'b0;
    req_if.bus_kind      = BUS_RD;
    req_if.line_state    = ST_I;
    req_if.line_addr     = '0;
    req_if.requester     = '0;
    rsp_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.protocol_mode = MODE_MESI;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_mesi_after_reset();
    test_mi_mode();
    test_msi_mode();
    test_mesi_mode();
    test_reserved_mode();
    test_mode_changes();

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("coherence_line_controller: match");
    end else begin
      $display("coherence_line_controller: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("coherence_line_controller: mismatch");
    $finish;
  end

endmodule

// ===== coherence_line_controller.f =====
sv/clc_pkg.sv
sv/clc_if.sv
sv/clc_front.sv
sv/clc_queue.sv
sv/clc_back.sv
sv/coherence_line_controller.sv
sv/clc_checker.sv
tb/sv/tb_coherence_line_controller.sv
